FILE: hdl/first_match_address_port_rule_classifier_core_defines.svh
// assertion macros for the first-match rule classifier
// used by the top level; expects clk and arst_n in scope
`ifndef FIRST_MATCH_ADDRESS_PORT_RULE_CLASSIFIER_CORE_DEFINES_SVH
`define FIRST_MATCH_ADDRESS_PORT_RULE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmc: next-cycle check failed");

`endif

FILE: hdl/fmc_pkg.sv
// shared types, constants and the port test for the rule classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fmc_pkg;

	localparam int MAX_RULES = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int LIMIT_W   = $clog2(MAX_RULES + 1);

	// item function codes
	localparam logic FUNC_WRITE    = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	// port comparison codes, test reads dst_port OP rule_port
	typedef enum logic [2:0] {
		CMP_LT     = 3'd0,
		CMP_EQ     = 3'd1,
		CMP_LE     = 3'd2,
		CMP_GT     = 3'd3,
		CMP_NE     = 3'd4,
		CMP_GE     = 3'd5,
		CMP_ALWAYS = 3'd6,
		CMP_NEVER  = 3'd7
	} cmp_t;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] rule_index;
		logic             rule_direct;
		logic [31:0]      rule_address;
		logic [31:0]      rule_netmask;
		logic [2:0]       rule_compare;
		logic [15:0]      rule_port;
		logic [31:0]      dst_address;
		logic [15:0]      dst_port;
	} in_beat_t;

	typedef struct packed {
		logic             go_direct;
		logic             rule_hit;
		logic [IDX_W-1:0] hit_index;
	} out_beat_t;

	// one stored rule
	typedef struct packed {
		logic        direct;
		logic [31:0] address;
		logic [31:0] mask;
		logic [2:0]  compare;
		logic [15:0] port;
	} rule_t;

	// query token that walks down the chain
	typedef struct packed {
		logic [31:0]        dst_address;
		logic [15:0]        dst_port;
		logic [LIMIT_W-1:0] pos;
		logic               hit;
		logic               direct;
		logic [IDX_W-1:0]   hit_index;
	} tok_t;

	function automatic logic port_test(cmp_t code, logic [15:0] dport, logic [15:0] rport);
		logic res;
		case (code)
			CMP_LT:     res = dport < rport;
			CMP_EQ:     res = dport == rport;
			CMP_LE:     res = dport <= rport;
			CMP_GT:     res = dport > rport;
			CMP_NE:     res = dport != rport;
			CMP_GE:     res = dport >= rport;
			CMP_ALWAYS: res = 1'b1;
			default:    res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/first_match_address_port_rule_classifier_core.sv
// top level of the first-match address/port rule classifier
// depends on fmc_pkg, fmc_cell and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "first_match_address_port_rule_classifier_core_defines.svh"

// Rules sit one per cell in a chain of MAX_RULES cells. A rule write (func 0)
// is taken when start is high and busy low and lands in its cell at that edge,
// so writes go at one per cycle and give no result. A classify beat (func 1)
// launches a query token that moves one cell per cycle; the first cell within
// rule_count whose masked address and port test hold marks the hit. The result
// beat is shown on result with done high for one cycle, once the token has
// passed the last of the MAX_RULES cells, and busy stays high through that
// cycle, so no new beat is taken while a classify is in the chain. The
// receiver cannot stall: a result must be taken in the cycle that done is
// high. rule_count is to be written via cfg_we/cfg_data only while idle; the
// block itself does not enforce this. Values above MAX_RULES act as MAX_RULES.
// No clearing pass after reset: cells scanned must have been written first.
module first_match_address_port_rule_classifier_core
	import fmc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire in_beat_t         item,
	output logic                  done,
	output out_beat_t             result,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data
);

	logic               busy_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               accept;
	logic               launch;
	rule_t              wr_rule;
	tok_t               head_tok;
	logic               chain_valid [MAX_RULES+1];
	tok_t               chain_tok   [MAX_RULES+1];

	assign busy   = busy_q;
	assign accept = start && !busy_q;
	assign launch = accept && (item.func == FUNC_CLASSIFY);

	// rule_count register, clamped to the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			if (32'(cfg_data) > MAX_RULES) begin
				limit_q <= LIMIT_W'(MAX_RULES);
			end else begin
				limit_q <= LIMIT_W'(cfg_data);
			end
		end
	end

	// busy from classify launch until its result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (launch) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// rule fields of a write beat and fresh token at the head of the chain
	always_comb begin
		wr_rule.direct  = item.rule_direct;
		wr_rule.address = item.rule_address;
		wr_rule.mask    = item.rule_netmask;
		wr_rule.compare = item.rule_compare;
		wr_rule.port    = item.rule_port;

		head_tok.dst_address = item.dst_address;
		head_tok.dst_port    = item.dst_port;
		head_tok.pos         = '0;
		head_tok.hit         = 1'b0;
		head_tok.direct      = 1'b0;
		head_tok.hit_index   = '0;
	end

	assign chain_valid[0] = launch;
	assign chain_tok[0]   = head_tok;

	// cell chain
	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		logic wr_sel;
		assign wr_sel = accept && (item.func == FUNC_WRITE) && (32'(item.rule_index) == i);

		fmc_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.wr_en         (wr_sel),
			.wr_rule       (wr_rule),
			.limit         (limit_q),
			.tok_in_valid  (chain_valid[i]),
			.tok_in        (chain_tok[i]),
			.tok_out_valid (chain_valid[i+1]),
			.tok_out       (chain_tok[i+1])
		);
	end

	// result beat from the tail cell
	always_comb begin
		done             = chain_valid[MAX_RULES];
		result.go_direct = chain_tok[MAX_RULES].direct;
		result.rule_hit  = chain_tok[MAX_RULES].hit;
		result.hit_index = chain_tok[MAX_RULES].hit_index;
	end

	`FMC_ASSERT_NOW(a_done_while_busy, done, busy_q)
	`FMC_ASSERT_NEXT(a_launch_sets_busy, launch, busy_q && !done)
	`FMC_ASSERT_NEXT(a_done_frees, done, !busy_q && !done)
	`FMC_ASSERT_NOW(a_miss_is_proxy, done && !result.rule_hit,
		!result.go_direct && (result.hit_index == '0))

endmodule

`default_nettype wire

FILE: hdl/fmc_cell.sv
// one rule cell: holds a rule and tests the passing query token against it
// depends on fmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmc_cell
	import fmc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire rule_t              wr_rule,
	input  wire logic [LIMIT_W-1:0] limit,
	input  wire logic               tok_in_valid,
	input  wire tok_t               tok_in,
	output logic                    tok_out_valid,
	output tok_t                    tok_out
);

	rule_t rule_q;
	logic  match;
	tok_t  tok_next;

	// rule storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_q <= wr_rule;
		end
	end

	// address under mask and port test, only inside the scanned range
	always_comb begin
		match = !tok_in.hit && (tok_in.pos < limit)
			&& (((rule_q.address ^ tok_in.dst_address) & rule_q.mask) == 32'd0)
			&& port_test(cmp_t'(rule_q.compare), tok_in.dst_port, rule_q.port);
		tok_next     = tok_in;
		tok_next.pos = tok_in.pos + LIMIT_W'(1);
		if (match) begin
			tok_next.hit       = 1'b1;
			tok_next.direct    = rule_q.direct;
			tok_next.hit_index = tok_in.pos[IDX_W-1:0];
		end
	end

	// token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_valid <= 1'b0;
		end else begin
			tok_out_valid <= tok_in_valid;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		tok_out <= tok_next;
	end

endmodule

`default_nettype wire

FILE: tb/tb_first_match_address_port_rule_classifier_core.sv
// self-checking testbench for the first-match address/port rule classifier
// depends on fmc_pkg and first_match_address_port_rule_classifier_core
// writes rule beats, classifies destinations, checks each verdict beat in order
`timescale 1ns / 1ps

module tb_first_match_address_port_rule_classifier_core;
	import fmc_pkg::*;

	// verdict predictor with its own rule table and rule count
	class rule_verdict_board;
		rule_t     rules [MAX_RULES];
		int        rule_count;
		out_beat_t verdicts_due [$];
		int        mismatches;

		function new();
			rule_count = 0;
			mismatches = 0;
			foreach (rules[i]) rules[i] = '0;
		endfunction

		// dst_port OP rule_port
		function bit port_holds(logic [2:0] code, logic [15:0] dport, logic [15:0] rport);
			bit ok;
			case (cmp_t'(code))
				CMP_LT:     ok = dport < rport;
				CMP_EQ:     ok = dport == rport;
				CMP_LE:     ok = dport <= rport;
				CMP_GT:     ok = dport > rport;
				CMP_NE:     ok = dport != rport;
				CMP_GE:     ok = dport >= rport;
				CMP_ALWAYS: ok = 1'b1;
				default:    ok = 1'b0;
			endcase
			return ok;
		endfunction

		// store a rule, or scan the table and queue the verdict
		function void take_beat(in_beat_t b);
			out_beat_t v;
			int        n;
			bit        found;
			if (b.func == FUNC_WRITE) begin
				rules[b.rule_index].direct  = b.rule_direct;
				rules[b.rule_index].address = b.rule_address;
				rules[b.rule_index].mask    = b.rule_netmask;
				rules[b.rule_index].compare = b.rule_compare;
				rules[b.rule_index].port    = b.rule_port;
				return;
			end
			n = (rule_count > MAX_RULES) ? MAX_RULES : rule_count;
			v = '0;
			found = 1'b0;
			for (int i = 0; i < n && !found; i++) begin
				if (((rules[i].address ^ b.dst_address) & rules[i].mask) == 32'h0 &&
					port_holds(rules[i].compare, b.dst_port, rules[i].port)) begin
					v.go_direct = rules[i].direct;
					v.rule_hit  = 1'b1;
					v.hit_index = IDX_W'(i);
					found = 1'b1;
				end
			end
			verdicts_due.push_back(v);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		// field by field against the oldest pending verdict
		task check_verdict(out_beat_t got);
			out_beat_t want;
			if (verdicts_due.size() == 0) begin
				report_mismatch("result beat with no verdict pending");
				return;
			end
			want = verdicts_due.pop_front();
			if (got.go_direct !== want.go_direct)
				report_mismatch($sformatf("go_direct %b, want %b", got.go_direct, want.go_direct));
			if (got.rule_hit !== want.rule_hit)
				report_mismatch($sformatf("rule_hit %b, want %b", got.rule_hit, want.rule_hit));
			if (got.hit_index !== want.hit_index)
				report_mismatch($sformatf("hit_index %0d, want %0d", got.hit_index,
					want.hit_index));
		endtask
	endclass

	localparam int unsigned CYCLE_LIMIT  = 600000;
	// scan length plus margin
	localparam int          DRAIN_CYCLES = 24;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_beat_t          item;
	logic              done;
	out_beat_t         result;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_data;
	int unsigned       cycles = 0;
	rule_verdict_board board;

	first_match_address_port_rule_classifier_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result beats cannot be held off, take each one as it shows
	always @(posedge clk) begin
		if (arst_n && done) board.check_verdict(result);
	end

	// present a beat and hold it until accepted
	task automatic send_beat(in_beat_t b);
		@(negedge clk);
		start <= 1'b1;
		item  <= b;
		do @(posedge clk); while (busy);
		board.take_beat(b);
	endtask

	// sender gap
	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// rule count write once the block has gone quiet
	task automatic set_rule_count(int unsigned n);
		@(negedge clk);
		start <= 1'b0;
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= CNT_W'(n);
		@(negedge clk);
		cfg_we <= 1'b0;
		board.rule_count = n;
	endtask

	// zero, all ones, random or prefix masks
	function automatic logic [31:0] pick_mask();
		case ($urandom_range(0, 4))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom();
			default: return 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
		endcase
	endfunction

	// ports on and around a boundary, plus the extremes
	function automatic logic [15:0] pick_port(logic [15:0] base);
		case ($urandom_range(0, 6))
			0:       return base;
			1:       return base + 16'd1;
			2:       return base - 16'd1;
			3:       return 16'h0;
			4:       return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic in_beat_t rule_write_beat(logic [IDX_W-1:0] idx);
		in_beat_t b;
		b.func         = FUNC_WRITE;
		b.rule_index   = idx;
		b.rule_direct  = 1'($urandom_range(0, 1));
		b.rule_address = $urandom();
		b.rule_netmask = pick_mask();
		b.rule_compare = 3'($urandom_range(0, 7));
		b.rule_port    = pick_port(16'($urandom()));
		b.dst_address  = $urandom();
		b.dst_port     = 16'($urandom());
		return b;
	endfunction

	// mostly aim at a scanned rule so matches and near misses are common
	function automatic in_beat_t classify_beat();
		in_beat_t b;
		rule_t    r;
		int       lim;
		b.func         = FUNC_CLASSIFY;
		b.rule_index   = IDX_W'($urandom());
		b.rule_direct  = 1'($urandom_range(0, 1));
		b.rule_address = $urandom();
		b.rule_netmask = $urandom();
		b.rule_compare = 3'($urandom());
		b.rule_port    = 16'($urandom());
		lim = (board.rule_count == 0 || board.rule_count > MAX_RULES) ? MAX_RULES
			: board.rule_count;
		r = board.rules[$urandom_range(0, lim - 1)];
		if ($urandom_range(0, 3) != 0) begin
			b.dst_address = (r.address & r.mask) | ($urandom() & ~r.mask);
			b.dst_port    = pick_port(r.port);
		end else begin
			b.dst_address = $urandom();
			b.dst_port    = 16'($urandom());
		end
		return b;
	endfunction

	initial begin : run
		in_beat_t    b;
		int unsigned idle_pct;
		int unsigned seg_count [6];
		logic [15:0] probe_port [8];

		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		board    = new();
		seg_count = '{16, 31, 1, 0, 9, $urandom_range(0, 31)};
		probe_port = '{16'd999, 16'd1000, 16'd1001, 16'd1001, 16'd1000, 16'd999,
			16'd0, 16'hFFFF};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// count is zero out of reset: nothing scanned, proxied verdict
		b = '0;
		b.func        = FUNC_CLASSIFY;
		b.dst_address = 32'hFFFF_FFFF;
		b.dst_port    = 16'hFFFF;
		send_beat(b);

		// exact-address rules, one per compare code, then prefix rules and a catch-all
		for (int i = 0; i < MAX_RULES; i++) begin
			b = '0;
			b.func        = FUNC_WRITE;
			b.rule_index  = IDX_W'(i);
			b.rule_direct = (i % 2 == 1);
			if (i < 8) begin
				b.rule_address = 32'h0A00_0000 + i;
				b.rule_netmask = 32'hFFFF_FFFF;
				b.rule_compare = 3'(i);
				b.rule_port    = 16'd1000;
			end else if (i < 15) begin
				b.rule_address = 32'hC0A8_0000 + i;
				b.rule_netmask = 32'hFFFF_0000;
				b.rule_compare = 3'(i - 8);
				b.rule_port    = (i % 2 == 0) ? 16'h0 : 16'hFFFF;
			end else begin
				b.rule_address = 32'hFFFF_FFFF;
				b.rule_netmask = 32'h0;
				b.rule_compare = CMP_ALWAYS;
				b.rule_port    = 16'h0;
			end
			send_beat(b);
		end
		set_rule_count(MAX_RULES);

		// port boundaries against each compare code, never code included
		for (int k = 0; k < 8; k++) begin
			b = '0;
			b.func        = FUNC_CLASSIFY;
			b.dst_address = 32'h0A00_0000 + k;
			b.dst_port    = probe_port[k];
			send_beat(b);
		end

		// random traffic over several rule counts and idling mixes
		for (int seg = 0; seg < 6; seg++) begin
			idle_pct = (seg < 2) ? 11 : (seg < 4) ? 62 : 0;
			set_rule_count(seg_count[seg]);
			repeat (300) begin
				// each offered cycle idles with the given odds
				while ($urandom_range(0, 99) < idle_pct)
					hold_off(1);
				if ($urandom_range(0, 99) < 30)
					send_beat(rule_write_beat(IDX_W'($urandom_range(0, MAX_RULES - 1))));
				else
					send_beat(classify_beat());
			end
		end

		// drain and settle
		@(negedge clk);
		start <= 1'b0;
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
